// ----- src/akvt_pkg.sv -----
// ----------------------------------------------------------------------------
// akvt_pkg
// Shared widths, codes and entry types of the attribute key/value table.
// ----------------------------------------------------------------------------
package akvt_pkg;

  localparam int unsigned ATTR_DEPTH    = 64;
  localparam int unsigned CLUSTER_DEPTH = 32;

  localparam int unsigned EP_W   = 16;
  localparam int unsigned CL_W   = 32;
  localparam int unsigned AT_W   = 32;
  localparam int unsigned TYPE_W = 8;
  localparam int unsigned FLAG_W = 8;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned ACNT_W = 7;
  localparam int unsigned CCNT_W = 6;

  localparam int unsigned AFILL_W = $clog2(ATTR_DEPTH + 1);
  localparam int unsigned CFILL_W = $clog2(CLUSTER_DEPTH + 1);
  localparam int unsigned AIDX_W  = (ATTR_DEPTH > 1) ? $clog2(ATTR_DEPTH) : 1;
  localparam int unsigned CIDX_W  = (CLUSTER_DEPTH > 1) ? $clog2(CLUSTER_DEPTH) : 1;
  localparam int unsigned IDX_W   = (AIDX_W > CIDX_W) ? AIDX_W : CIDX_W;
  localparam int unsigned FILL_W  = (AFILL_W > CFILL_W) ? AFILL_W : CFILL_W;
  localparam int unsigned CMP_W   = (IDX_W > FILL_W) ? IDX_W : FILL_W;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_GET   = 2'd1,
    MODE_SET   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_SAME = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [EP_W-1:0] ep;
    logic [CL_W-1:0] cl;
  } clus_key_t;

  typedef struct packed {
    logic [EP_W-1:0] ep;
    logic [CL_W-1:0] cl;
    logic [AT_W-1:0] at;
  } attr_key_t;

  typedef struct packed {
    attr_key_t         key;
    logic [TYPE_W-1:0] vtype;
    logic [FLAG_W-1:0] flags;
    logic [VAL_W-1:0]  value;
  } attr_entry_t;

  typedef struct packed {
    logic              ins;
    logic              upd_meta;
    logic              upd_val;
    logic [TYPE_W-1:0] vtype;
    logic [FLAG_W-1:0] flags;
    logic [VAL_W-1:0]  value;
  } attr_ctl_t;

endpackage

// ----- src/akvt_clus_cell.sv -----
// ----------------------------------------------------------------------------
// akvt_clus_cell
// One cluster entry of the rotating cluster ring: holds the entry, compares
// it with the search key and passes it on, or a new entry, to its neighbour.
// ----------------------------------------------------------------------------
module akvt_clus_cell import akvt_pkg::*; (
  input  logic      clk_i,
  input  logic      shift_i,
  input  clus_key_t key_i,
  input  logic      ins_i,
  input  clus_key_t d_i,
  output clus_key_t p_o,
  output logic      hit_o
);

  clus_key_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign hit_o = (entry_q == key_i);
  assign p_o   = ins_i ? key_i : entry_q;

endmodule

// ----- src/akvt_attr_cell.sv -----
// ----------------------------------------------------------------------------
// akvt_attr_cell
// One attribute entry of the rotating attribute ring: holds the entry,
// matches it against the search key and hands it on, updated if asked.
// ----------------------------------------------------------------------------
module akvt_attr_cell import akvt_pkg::*; (
  input  logic        clk_i,
  input  logic        shift_i,
  input  attr_key_t   key_i,
  input  attr_ctl_t   ctl_i,
  input  attr_entry_t d_i,
  output attr_entry_t p_o,
  output logic        hit_o,
  output logic        same_o
);

  attr_entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign hit_o  = (entry_q.key == key_i);
  assign same_o = (entry_q.value == ctl_i.value);

  always_comb begin
    p_o = entry_q;
    if (ctl_i.ins) begin
      p_o.key = key_i;
    end
    if (ctl_i.ins || ctl_i.upd_meta) begin
      p_o.vtype = ctl_i.vtype;
      p_o.flags = ctl_i.flags;
    end
    if (ctl_i.ins || ctl_i.upd_val) begin
      p_o.value = ctl_i.value;
    end
  end

endmodule

// ----- src/attribute_key_value_table.sv -----
// ----------------------------------------------------------------------------
// attribute_key_value_table
// Append-only attribute and cluster tables searched by exact key match.
// ----------------------------------------------------------------------------
// Each table is a ring of cells that rotates one place per cycle while its
// pass runs; the entry at the head of the ring is compared, updated or
// written, so one full pass visits every entry once and leaves the ring as
// it was. A request is taken when start is high and busy is low. Clear
// gives its result in the next cycle. Get and set make one attribute pass.
// Add makes a cluster pass and then an attribute pass, or only the cluster
// pass when the cluster table is full and lacks the key. The result is
// shown for exactly one cycle with done_o high; it cannot be held off, so
// sample it then. The counts stay valid until the next request. No clearing
// pass is needed after reset.
module attribute_key_value_table import akvt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode_i,
  input  logic [EP_W-1:0]   endpoint_id_i,
  input  logic [CL_W-1:0]   cluster_id_i,
  input  logic [AT_W-1:0]   attribute_id_i,
  input  logic [TYPE_W-1:0] value_type_i,
  input  logic [FLAG_W-1:0] entry_flags_i,
  input  logic [VAL_W-1:0]  data_value_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [VAL_W-1:0]  read_value_o,
  output logic [ACNT_W-1:0] attribute_count_o,
  output logic [CCNT_W-1:0] cluster_count_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CLUS = 3'b010,
    S_ATTR = 3'b100
  } state_e;

  typedef struct packed {
    mode_e             mode;
    attr_key_t         key;
    logic [TYPE_W-1:0] vtype;
    logic [FLAG_W-1:0] flags;
    logic [VAL_W-1:0]  value;
  } req_t;

  state_e               state_q, state_d;
  req_t                 req_q, req_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 found_q, found_d;
  logic [AFILL_W-1:0]   afill_q, afill_d;
  logic [CFILL_W-1:0]   cfill_q, cfill_d;
  status_e              status_q, status_d;
  logic [VAL_W-1:0]     rv_q, rv_d;
  logic                 done_q, done_d;

  logic                 clus_shift, attr_shift;
  logic                 clus_ins;
  attr_ctl_t            attr_ctl;
  logic                 clus_head_hit, attr_head_hit, attr_head_same;
  logic                 in_range, hit, ins, last;
  clus_key_t            clus_key;
  clus_key_t            clus_p [CLUSTER_DEPTH];
  attr_entry_t          attr_p [ATTR_DEPTH];

  assign clus_key = '{ep: req_q.key.ep, cl: req_q.key.cl};

  // Cluster ring: cell k takes from cell k+1, the last from the head.
  for (genvar k = 0; k < CLUSTER_DEPTH; k++) begin : g_clus
    localparam int unsigned NXT = (k + 1) % CLUSTER_DEPTH;
    if (k == 0) begin : g_head
      akvt_clus_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (clus_shift),
        .key_i   (clus_key),
        .ins_i   (clus_ins),
        .d_i     (clus_p[NXT]),
        .p_o     (clus_p[k]),
        .hit_o   (clus_head_hit)
      );
    end else begin : g_body
      akvt_clus_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (clus_shift),
        .key_i   (clus_key),
        .ins_i   (1'b0),
        .d_i     (clus_p[NXT]),
        .p_o     (clus_p[k]),
        .hit_o   ()
      );
    end
  end

  for (genvar k = 0; k < ATTR_DEPTH; k++) begin : g_attr
    localparam int unsigned NXT = (k + 1) % ATTR_DEPTH;
    if (k == 0) begin : g_head
      akvt_attr_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (attr_shift),
        .key_i   (req_q.key),
        .ctl_i   (attr_ctl),
        .d_i     (attr_p[NXT]),
        .p_o     (attr_p[k]),
        .hit_o   (attr_head_hit),
        .same_o  (attr_head_same)
      );
    end else begin : g_body
      akvt_attr_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (attr_shift),
        .key_i   (req_q.key),
        .ctl_i   ('0),
        .d_i     (attr_p[NXT]),
        .p_o     (attr_p[k]),
        .hit_o   (),
        .same_o  ()
      );
    end
  end

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    idx_d      = idx_q;
    found_d    = found_q;
    afill_d    = afill_q;
    cfill_d    = cfill_q;
    status_d   = status_q;
    rv_d       = rv_q;
    done_d     = 1'b0;
    clus_shift = 1'b0;
    attr_shift = 1'b0;
    clus_ins   = 1'b0;
    in_range   = 1'b0;
    hit        = 1'b0;
    ins        = 1'b0;
    last       = 1'b0;
    attr_ctl          = '0;
    attr_ctl.vtype    = req_q.vtype;
    attr_ctl.flags    = req_q.flags;
    attr_ctl.value    = req_q.value;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d.mode   = mode_e'(mode_i);
          req_d.key.ep = endpoint_id_i;
          req_d.key.cl = cluster_id_i;
          req_d.key.at = attribute_id_i;
          req_d.vtype  = value_type_i;
          req_d.flags  = entry_flags_i;
          req_d.value  = data_value_i;
          idx_d        = '0;
          found_d      = 1'b0;
          status_d     = ST_OK;
          rv_d         = '0;
          case (mode_e'(mode_i))
            MODE_CLEAR: begin
              afill_d = '0;
              cfill_d = '0;
              done_d  = 1'b1;
            end
            MODE_ADD: state_d = S_CLUS;
            default:  state_d = S_ATTR;
          endcase
        end
      end

      S_CLUS: begin
        clus_shift = 1'b1;
        in_range   = CMP_W'(idx_q) < CMP_W'(cfill_q);
        hit        = clus_head_hit && in_range && !found_q;
        ins        = !found_q && (CMP_W'(idx_q) == CMP_W'(cfill_q)) &&
                     (CMP_W'(cfill_q) < CMP_W'(CLUSTER_DEPTH));
        last       = CMP_W'(idx_q) == CMP_W'(CLUSTER_DEPTH - 1);
        clus_ins   = ins;
        if (ins) begin
          cfill_d = cfill_q + 1'b1;
        end
        if (hit || ins) begin
          found_d = 1'b1;
        end
        if (last) begin
          idx_d   = '0;
          found_d = 1'b0;
          if (found_q || hit || ins) begin
            state_d = S_ATTR;
          end else begin
            status_d = ST_FULL;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_ATTR: begin
        attr_shift = 1'b1;
        in_range   = CMP_W'(idx_q) < CMP_W'(afill_q);
        hit        = attr_head_hit && in_range && !found_q;
        last       = CMP_W'(idx_q) == CMP_W'(ATTR_DEPTH - 1);
        case (req_q.mode)
          MODE_ADD: begin
            ins = !found_q && (CMP_W'(idx_q) == CMP_W'(afill_q)) &&
                  (CMP_W'(afill_q) < CMP_W'(ATTR_DEPTH));
            attr_ctl.ins      = ins;
            attr_ctl.upd_meta = hit;
            attr_ctl.upd_val  = hit;
            if (ins) begin
              afill_d = afill_q + 1'b1;
            end
          end
          MODE_GET: begin
            if (hit) begin
              rv_d = attr_p[0].value;
            end
          end
          MODE_SET: begin
            attr_ctl.upd_val = hit && !attr_head_same;
            if (hit && attr_head_same) begin
              status_d = ST_SAME;
            end
          end
          default: ;
        endcase
        if (hit || ins) begin
          found_d = 1'b1;
        end
        if (last) begin
          idx_d   = '0;
          found_d = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (!(found_q || hit || ins)) begin
            status_d = (req_q.mode == MODE_ADD) ? ST_FULL : ST_MISS;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      found_q <= 1'b0;
      afill_q <= '0;
      cfill_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      afill_q <= afill_d;
      cfill_q <= cfill_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    status_q <= status_d;
    rv_q     <= rv_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign read_value_o      = rv_q;
  assign attribute_count_o = ACNT_W'(afill_q);
  assign cluster_count_o   = CCNT_W'(cfill_q);

endmodule

// ----- src/akvt_checker.sv -----
// ----------------------------------------------------------------------------
// akvt_checker
// Port-level checks of the attribute key/value table, bound to the top level.
// ----------------------------------------------------------------------------
module akvt_checker import akvt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [1:0]        mode_i,
  input logic              done_o,
  input logic [1:0]        status_o,
  input logic [VAL_W-1:0]  read_value_o,
  input logic [ACNT_W-1:0] attribute_count_o,
  input logic [CCNT_W-1:0] cluster_count_o
);

  // Table requests hold busy for their scan
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i != MODE_CLEAR) |=> busy)
    else $error("table request did not raise busy");

  // Clear answers next cycle with empty tables
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_CLEAR) |=>
      (done_o && status_o == ST_OK && attribute_count_o == '0 &&
       cluster_count_o == '0))
    else $error("clear result wrong");

  // Only a successful get may carry a value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (read_value_o == '0))
    else $error("read value on a failed transaction");

  // An attribute is never stored without its cluster
  a_cluster_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && attribute_count_o != '0) |-> (cluster_count_o != '0))
    else $error("attribute present with empty cluster table");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

endmodule

bind attribute_key_value_table akvt_checker u_akvt_checker (.*);

// ----- sim/attribute_key_value_table_test.sv -----
// ----------------------------------------------------------------------------
// attribute_key_value_table_test
// Self-checking bench for the attribute/cluster key-value table: a short table
// of directed requests, then sessions of random add/get/set/clear traffic over
// small key pools, so both tables fill up, overflow and get cleared. Each
// result is checked against its typed-in expectation or, if none, a behavioural copy of both tables.
// ----------------------------------------------------------------------------
module attribute_key_value_table_test import akvt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_ITEMS     = 1400;
  localparam int unsigned TAIL_ITEMS  = 150;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN       = ATTR_DEPTH + CLUSTER_DEPTH + 8;
  localparam int unsigned N_DIRECTED  = 24;

  typedef struct packed {
    mode_e             mode;
    logic [EP_W-1:0]   ep;
    logic [CL_W-1:0]   cl;
    logic [AT_W-1:0]   at;
    logic [TYPE_W-1:0] vtype;
    logic [FLAG_W-1:0] flags;
    logic [VAL_W-1:0]  value;
  } request_t;

  typedef struct packed {
    status_e           status;
    logic [VAL_W-1:0]  value;
    logic [ACNT_W-1:0] acnt;
    logic [CCNT_W-1:0] ccnt;
  } outcome_t;

  typedef struct packed {
    request_t rq;
    logic     typed;
    outcome_t want;
  } stim_row_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic [1:0]        mode_i         = '0;
  logic [EP_W-1:0]   endpoint_id_i  = '0;
  logic [CL_W-1:0]   cluster_id_i   = '0;
  logic [AT_W-1:0]   attribute_id_i = '0;
  logic [TYPE_W-1:0] value_type_i   = '0;
  logic [FLAG_W-1:0] entry_flags_i  = '0;
  logic [VAL_W-1:0]  data_value_i   = '0;
  logic              done_o;
  logic [1:0]        status_o;
  logic [VAL_W-1:0]  read_value_o;
  logic [ACNT_W-1:0] attribute_count_o;
  logic [CCNT_W-1:0] cluster_count_o;

  // Typed-in expectation travelling with the transaction on the bus
  logic     req_typed = 1'b0;
  outcome_t req_want  = '0;

  // Shadow tables; type and flags never reach the outputs, so they are not kept
  attr_key_t        attr_tab [ATTR_DEPTH];
  logic [VAL_W-1:0] attr_val [ATTR_DEPTH];
  clus_key_t        clus_tab [CLUSTER_DEPTH];
  int unsigned      attr_fill = 0;
  int unsigned      clus_fill = 0;

  outcome_t    pending_results [$];
  int unsigned items_sent   = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_count   = 0;

  attribute_key_value_table i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .endpoint_id_i    (endpoint_id_i),
    .cluster_id_i     (cluster_id_i),
    .attribute_id_i   (attribute_id_i),
    .value_type_i     (value_type_i),
    .entry_flags_i    (entry_flags_i),
    .data_value_i     (data_value_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .attribute_count_o(attribute_count_o),
    .cluster_count_o  (cluster_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int find_attr(input request_t rq);
    for (int i = 0; i < int'(attr_fill); i++) begin
      if (attr_tab[i].ep == rq.ep && attr_tab[i].cl == rq.cl && attr_tab[i].at == rq.at) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic outcome_t apply_request(input request_t rq);
    outcome_t res;
    int       slot;
    logic     have_cluster;
    res        = '0;
    res.status = ST_OK;
    case (rq.mode)
      MODE_ADD: begin
        have_cluster = 1'b0;
        for (int i = 0; i < int'(clus_fill); i++) begin
          if (clus_tab[i].ep == rq.ep && clus_tab[i].cl == rq.cl) have_cluster = 1'b1;
        end
        if (!have_cluster && clus_fill < CLUSTER_DEPTH) begin
          clus_tab[clus_fill].ep = rq.ep;
          clus_tab[clus_fill].cl = rq.cl;
          clus_fill++;
          have_cluster = 1'b1;
        end
        if (!have_cluster) begin
          res.status = ST_FULL;
        end else begin
          slot = find_attr(rq);
          // a cluster inserted above stays even when the attribute does not fit
          if (slot < 0 && attr_fill >= ATTR_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            if (slot < 0) begin
              slot = int'(attr_fill);
              attr_tab[slot].ep = rq.ep;
              attr_tab[slot].cl = rq.cl;
              attr_tab[slot].at = rq.at;
              attr_fill++;
            end
            attr_val[slot] = rq.value;
          end
        end
      end
      MODE_GET: begin
        slot = find_attr(rq);
        if (slot < 0) res.status = ST_MISS;
        else res.value = attr_val[slot];
      end
      MODE_SET: begin
        slot = find_attr(rq);
        if (slot < 0) res.status = ST_MISS;
        else if (attr_val[slot] == rq.value) res.status = ST_SAME;
        else attr_val[slot] = rq.value;
      end
      default: begin
        attr_fill = 0;
        clus_fill = 0;
      end
    endcase
    res.acnt = ACNT_W'(attr_fill);
    res.ccnt = CCNT_W'(clus_fill);
    return res;
  endfunction

  // Check results and log accepted requests, both on the same edge
  always @(posedge clk_i) begin : scoreboard
    outcome_t oldest;
    outcome_t predicted;
    request_t taken;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", status_o);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (status_o !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, status_o);
            fail_count++;
          end
          if (read_value_o !== oldest.value) begin
            $error("read_value: expected %h, got %h", oldest.value, read_value_o);
            fail_count++;
          end
          if (attribute_count_o !== oldest.acnt) begin
            $error("attribute_count: expected %0d, got %0d", oldest.acnt, attribute_count_o);
            fail_count++;
          end
          if (cluster_count_o !== oldest.ccnt) begin
            $error("cluster_count: expected %0d, got %0d", oldest.ccnt, cluster_count_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        taken     = '{mode_e'(mode_i), endpoint_id_i, cluster_id_i, attribute_id_i,
                      value_type_i, entry_flags_i, data_value_i};
        predicted = apply_request(taken);
        pending_results.push_back(req_typed ? req_want : predicted);
      end
      if (done_o || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic issue(input request_t rq, input logic typed, input outcome_t want);
    start          <= 1'b1;
    mode_i         <= rq.mode;
    endpoint_id_i  <= rq.ep;
    cluster_id_i   <= rq.cl;
    attribute_id_i <= rq.at;
    value_type_i   <= rq.vtype;
    entry_flags_i  <= rq.flags;
    data_value_i   <= rq.value;
    req_typed      <= typed;
    req_want       <= want;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  // Drop start for a burst, sometimes only once the block has gone idle
  task automatic sender_gap();
    start <= 1'b0;
    if ($urandom_range(0, 1)) begin
      do @(posedge clk_i); while (busy);
    end
    repeat ($urandom_range(1, 15)) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t       directed [N_DIRECTED];
    request_t        rq;
    logic [EP_W-1:0] ep_pool [4];
    logic [CL_W-1:0] cl_pool [12];
    logic [AT_W-1:0] at_pool [8];
    int unsigned     n_ep, n_cl, n_at, n_ops, pick;
    logic            quiet;

    directed = '{
      '{'{MODE_GET, 16'h0, 32'h0, 32'h0, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_MISS, 64'h0, 7'd0, 6'd0}},
      '{'{MODE_SET, 16'h0, 32'h0, 32'h0, 8'h00, 8'h00, 64'h1}, 1'b1,
        '{ST_MISS, 64'h0, 7'd0, 6'd0}},
      '{'{MODE_ADD, 16'h0, 32'h0, 32'h0, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_OK, 64'h0, 7'd1, 6'd1}},
      '{'{MODE_GET, 16'h0, 32'h0, 32'h0, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_OK, 64'h0, 7'd1, 6'd1}},
      '{'{MODE_SET, 16'h0, 32'h0, 32'h0, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_SAME, 64'h0, 7'd1, 6'd1}},
      '{'{MODE_SET, 16'h0, 32'h0, 32'h0, 8'h00, 8'h00, '1}, 1'b1,
        '{ST_OK, 64'h0, 7'd1, 6'd1}},
      '{'{MODE_GET, 16'h0, 32'h0, 32'h0, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_OK, '1, 7'd1, 6'd1}},
      '{'{MODE_ADD, '1, '1, '1, 8'hFF, 8'hFF, '1}, 1'b1,
        '{ST_OK, 64'h0, 7'd2, 6'd2}},
      '{'{MODE_ADD, '1, '1, 32'h0, 8'hA5, 8'h5A, 64'h8000_0000_0000_0001}, 1'b1,
        '{ST_OK, 64'h0, 7'd3, 6'd2}},
      '{'{MODE_ADD, '1, '1, 32'h0, 8'h3C, 8'hC3, 64'h5}, 1'b1,
        '{ST_OK, 64'h0, 7'd3, 6'd2}},
      '{'{MODE_GET, '1, '1, 32'h0, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_OK, 64'h5, 7'd3, 6'd2}},
      '{'{MODE_GET, '1, 32'h0, 32'h0, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_MISS, 64'h0, 7'd3, 6'd2}},
      '{'{MODE_GET, 16'h0, '1, '1, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_MISS, 64'h0, 7'd3, 6'd2}},
      '{'{MODE_SET, '1, '1, 32'hFFFF_FFFE, 8'h00, 8'h00, 64'h9}, 1'b1,
        '{ST_MISS, 64'h0, 7'd3, 6'd2}},
      '{'{MODE_ADD, 16'h1234, 32'hDEAD_BEEF, 32'h100, 8'h12, 8'h34,
          64'h0123_4567_89AB_CDEF}, 1'b0, '0},
      '{'{MODE_ADD, 16'h1234, 32'hDEAD_BEEF, 32'h101, 8'h56, 8'h78,
          64'h0123_4567_89AB_CDEF}, 1'b0, '0},
      '{'{MODE_SET, 16'h1234, 32'hDEAD_BEEF, 32'h101, 8'h00, 8'h00,
          64'hFEDC_BA98_7654_3210}, 1'b0, '0},
      '{'{MODE_GET, 16'h1234, 32'hDEAD_BEEF, 32'h101, 8'h00, 8'h00, 64'h0}, 1'b0, '0},
      '{'{MODE_CLEAR, '1, '1, '1, 8'hFF, 8'hFF, '1}, 1'b1,
        '{ST_OK, 64'h0, 7'd0, 6'd0}},
      '{'{MODE_GET, 16'h0, 32'h0, 32'h0, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_MISS, 64'h0, 7'd0, 6'd0}},
      '{'{MODE_SET, '1, '1, '1, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_MISS, 64'h0, 7'd0, 6'd0}},
      '{'{MODE_ADD, 16'h0, 32'h0, 32'h0, 8'h01, 8'h80, 64'h7}, 1'b1,
        '{ST_OK, 64'h0, 7'd1, 6'd1}},
      '{'{MODE_GET, 16'h0, 32'h0, 32'h0, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_OK, 64'h7, 7'd1, 6'd1}},
      '{'{MODE_CLEAR, 16'h0, 32'h0, 32'h0, 8'h00, 8'h00, 64'h0}, 1'b1,
        '{ST_OK, 64'h0, 7'd0, 6'd0}}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      issue(directed[i].rq, directed[i].typed, directed[i].want);
      if ($urandom_range(0, 3) == 0) sender_gap();
    end

    // Sessions: clear, then traffic over a fresh key pool sized to hit both full cases
    while (items_sent < N_ITEMS) begin
      // hold off until every result is in, except in the back-to-back tail
      if (items_sent < N_ITEMS - TAIL_ITEMS) begin
        start <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end

      if ($urandom_range(0, 1)) begin
        n_ep  = 4;
        n_cl  = $urandom_range(9, 12);
        n_ops = $urandom_range(150, 260);
      end else begin
        n_ep  = $urandom_range(1, 4);
        n_cl  = $urandom_range(1, 12);
        n_ops = $urandom_range(60, 160);
      end
      n_at  = $urandom_range(1, 8);
      quiet = ($urandom_range(0, 2) == 0);
      foreach (ep_pool[i]) ep_pool[i] = EP_W'(pick_key());
      foreach (cl_pool[i]) cl_pool[i] = pick_key();
      foreach (at_pool[i]) at_pool[i] = pick_key();

      rq       = '0;
      rq.mode  = MODE_CLEAR;
      rq.value = {$urandom, $urandom};
      issue(rq, 1'b0, '0);

      for (int k = 0; k < int'(n_ops) && items_sent < N_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) rq.mode = MODE_ADD;
        else if (pick < 72) rq.mode = MODE_GET;
        else if (pick < 98) rq.mode = MODE_SET;
        else rq.mode = MODE_CLEAR;
        if ($urandom_range(0, 15) == 0) begin
          rq.ep = EP_W'($urandom);
          rq.cl = $urandom;
          rq.at = $urandom;
        end else begin
          rq.ep = ep_pool[$urandom_range(0, n_ep - 1)];
          rq.cl = cl_pool[$urandom_range(0, n_cl - 1)];
          rq.at = at_pool[$urandom_range(0, n_at - 1)];
        end
        rq.vtype = TYPE_W'($urandom);
        rq.flags = FLAG_W'($urandom);
        // small values make unchanged sets common
        rq.value = $urandom_range(0, 1) ? VAL_W'($urandom_range(0, 3)) : {$urandom, $urandom};
        issue(rq, 1'b0, '0);
        if (!quiet && items_sent < N_ITEMS - TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
          sender_gap();
        end
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
